### hdl/line_rasterizer_assert.svh
// Assertion macros used by the line rasterizer RTL.
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define LR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define LR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/lr_pkg.sv
// Shared types and constants of the line rasterizer.
package lr_pkg;

	// width of a surface size register on the configuration port
	localparam int unsigned CFG_W = 13;

	// input word kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	// configuration register indexes
	localparam logic CFG_SURFACE_WIDTH  = 1'b0;
	localparam logic CFG_SURFACE_HEIGHT = 1'b1;

	// pen moves decided for one step
	typedef struct packed {
		logic move_x;
		logic move_y;
	} move_t;

endpackage

### hdl/line_rasterizer.sv
// Line rasterizer: an accepted step word gives its pixel word in the next cycle.
// One word per cycle while in_stall is low; the single step unit (lr_step) updates
// the pen and error term in the same cycle the step word is accepted.
// The output register stalls the input only while it holds a pixel that is stalled.
// Reset (arst_n low, asynchronous): no line active, line state cleared, output
// empty, surface size registers at MAX_DIM.
`include "line_rasterizer_assert.svh"

module line_rasterizer #(
	parameter int unsigned COORD_WIDTH = 16,
	parameter int unsigned MAX_DIM     = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic signed [COORD_WIDTH-1:0] from_x,
	input  logic signed [COORD_WIDTH-1:0] from_y,
	input  logic signed [COORD_WIDTH-1:0] to_x,
	input  logic signed [COORD_WIDTH-1:0] to_y,
	input  logic        [15:0]            line_color,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] pixel_x,
	output logic signed [COORD_WIDTH-1:0] pixel_y,
	output logic        [15:0]            pixel_color,
	output logic                          on_surface,
	output logic                          last_pixel,
	// configuration port
	input  logic                          cfg_write,
	input  logic                          cfg_index,
	input  logic [lr_pkg::CFG_W-1:0]      cfg_data
);
	// width that holds any surface size up to MAX_DIM
	localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
	// common width for the clip compares
	localparam int unsigned CMP_W = ((COORD_WIDTH > DIM_W) ? COORD_WIDTH : DIM_W) + 1;
	localparam int unsigned SAT_W = (lr_pkg::CFG_W > DIM_W) ? lr_pkg::CFG_W : DIM_W;

	// surface size registers
	logic [DIM_W-1:0] surface_width_q;
	logic [DIM_W-1:0] surface_height_q;
	logic [SAT_W-1:0] cfg_ext;
	logic [SAT_W-1:0] max_ext;
	logic [DIM_W-1:0] cfg_sat;

	// line state
	logic                          drawing_q;
	logic signed [COORD_WIDTH-1:0] pen_x_q;
	logic signed [COORD_WIDTH-1:0] pen_y_q;
	logic signed [COORD_WIDTH-1:0] target_x_q;
	logic signed [COORD_WIDTH-1:0] target_y_q;
	logic                          step_left_q;
	logic                          step_up_q;
	logic        [COORD_WIDTH:0]   span_x_q;
	logic        [COORD_WIDTH:0]   span_y_q;
	logic signed [COORD_WIDTH+1:0] error_term_q;
	logic        [15:0]            held_color_q;

	// output register
	logic                          out_valid_q;
	logic signed [COORD_WIDTH-1:0] pixel_x_q;
	logic signed [COORD_WIDTH-1:0] pixel_y_q;
	logic        [15:0]            pixel_color_q;
	logic                          on_surface_q;
	logic                          last_pixel_q;

	// per-word logic
	logic                          in_fire;
	logic                          out_fire;
	logic                          emit;
	logic                          at_end;
	logic                          on_now;
	logic signed [COORD_WIDTH:0]   dx;
	logic signed [COORD_WIDTH:0]   dy;
	logic signed [COORD_WIDTH+1:0] error_next;
	lr_pkg::move_t                 move;

	// The input may advance when the output register is empty or drains this cycle.
	assign in_stall = out_valid_q && out_stall;
	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid_q && !out_stall;

	// A step word on an active line produces exactly one pixel.
	assign emit   = in_fire && (kind == lr_pkg::KIND_STEP) && drawing_q;
	assign at_end = (pen_x_q == target_x_q) && (pen_y_q == target_y_q);

	// Clip test: column and row must be non-negative and below the surface size.
	assign on_now = !pen_x_q[COORD_WIDTH-1] && !pen_y_q[COORD_WIDTH-1]
		&& (CMP_W'($unsigned(pen_x_q)) < CMP_W'(surface_width_q))
		&& (CMP_W'($unsigned(pen_y_q)) < CMP_W'(surface_height_q));

	// Endpoint deltas for a load word.
	assign dx = (COORD_WIDTH+1)'(to_x) - (COORD_WIDTH+1)'(from_x);
	assign dy = (COORD_WIDTH+1)'(to_y) - (COORD_WIDTH+1)'(from_y);

	// Saturate a configuration write at MAX_DIM.
	assign cfg_ext = SAT_W'(cfg_data);
	assign max_ext = SAT_W'(MAX_DIM);
	assign cfg_sat = (cfg_ext > max_ext) ? DIM_W'(MAX_DIM) : DIM_W'(cfg_ext);

	lr_step #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_step (
		.error_term(error_term_q),
		.span_x    (span_x_q),
		.span_y    (span_y_q),
		.move      (move),
		.error_next(error_next)
	);

	// Surface size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surface_width_q  <= DIM_W'(MAX_DIM);
			surface_height_q <= DIM_W'(MAX_DIM);
		end else if (cfg_write) begin
			case (cfg_index)
				lr_pkg::CFG_SURFACE_WIDTH:  surface_width_q  <= cfg_sat;
				lr_pkg::CFG_SURFACE_HEIGHT: surface_height_q <= cfg_sat;
				default: ;
			endcase
		end
	end

	// Line active flag: set on load, drop after the end point is given.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drawing_q <= 1'b0;
		end else if (in_fire) begin
			if (kind == lr_pkg::KIND_LOAD) begin
				drawing_q <= 1'b1;
			end else if (emit && at_end) begin
				drawing_q <= 1'b0;
			end
		end
	end

	// Line state: load the setup, or advance the pen after a pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q      <= '0;
			pen_y_q      <= '0;
			target_x_q   <= '0;
			target_y_q   <= '0;
			step_left_q  <= 1'b0;
			step_up_q    <= 1'b0;
			span_x_q     <= '0;
			span_y_q     <= '0;
			error_term_q <= '0;
			held_color_q <= '0;
		end else if (in_fire && (kind == lr_pkg::KIND_LOAD)) begin
			pen_x_q      <= from_x;
			pen_y_q      <= from_y;
			target_x_q   <= to_x;
			target_y_q   <= to_y;
			step_left_q  <= dx[COORD_WIDTH];
			step_up_q    <= dy[COORD_WIDTH];
			span_x_q     <= dx[COORD_WIDTH] ? $unsigned(-dx) : $unsigned(dx);
			span_y_q     <= dy[COORD_WIDTH] ? $unsigned(-dy) : $unsigned(dy);
			error_term_q <= (COORD_WIDTH+2)'(dx[COORD_WIDTH] ? -dx : dx)
				- (COORD_WIDTH+2)'(dy[COORD_WIDTH] ? -dy : dy);
			held_color_q <= line_color;
		end else if (emit && !at_end) begin
			error_term_q <= error_next;
			if (move.move_x) begin
				pen_x_q <= pen_x_q + {{(COORD_WIDTH-1){step_left_q}}, 1'b1};
			end
			if (move.move_y) begin
				pen_y_q <= pen_y_q + {{(COORD_WIDTH-1){step_up_q}}, 1'b1};
			end
		end
	end

	// Output valid: fill on a pixel, empty when the word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload: capture the pen pixel, hold it while stalled.
	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_x_q     <= pen_x_q;
			pixel_y_q     <= pen_y_q;
			pixel_color_q <= held_color_q;
			on_surface_q  <= on_now;
			last_pixel_q  <= at_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_color = pixel_color_q;
	assign on_surface  = on_surface_q;
	assign last_pixel  = last_pixel_q;

	// A step word on an active line must show up as a pixel word.
	`LR_ASSERT_NEXT(a_step_emits, emit, out_valid_q, "step on active line gave no pixel")
	// The end point closes the line.
	`LR_ASSERT_NEXT(a_end_closes, emit && at_end, !drawing_q, "line still active after end point")
	// A step word while idle leaves the pen alone and starts nothing.
	`LR_ASSERT_NEXT(a_idle_step, in_fire && (kind == lr_pkg::KIND_STEP) && !drawing_q,
		!drawing_q && $stable(pen_x_q) && $stable(pen_y_q), "idle step changed line state")

endmodule

### hdl/lr_step.sv
// Bresenham step decision and error term update for one pixel.
module lr_step #(
	parameter int unsigned COORD_WIDTH = 16
) (
	input  logic signed [COORD_WIDTH+1:0] error_term,
	input  logic        [COORD_WIDTH:0]   span_x,
	input  logic        [COORD_WIDTH:0]   span_y,
	output lr_pkg::move_t                 move,
	output logic signed [COORD_WIDTH+1:0] error_next
);
	localparam int unsigned EW = COORD_WIDTH + 3;

	logic signed [EW-1:0] err_ext;
	logic signed [EW-1:0] e2;
	logic signed [EW-1:0] sx_ext;
	logic signed [EW-1:0] sy_ext;
	logic signed [EW-1:0] sum;

	always_comb begin
		err_ext = EW'(error_term);
		e2      = {error_term, 1'b0};
		sx_ext  = $signed({2'b00, span_x});
		sy_ext  = $signed({2'b00, span_y});
		move.move_x = (e2 > -sy_ext);
		move.move_y = (e2 < sx_ext);
		sum = err_ext;
		if (move.move_x) begin
			sum = sum - sy_ext;
		end
		if (move.move_y) begin
			sum = sum + sx_ext;
		end
		error_next = sum[COORD_WIDTH+1:0];
	end

endmodule

### dv/tb_line_rasterizer.sv
// Self-checking testbench for the line rasterizer: directed lines, then random phases.
module tb_line_rasterizer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_W      = 16;
	localparam int DIM_MAX      = 4096;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 4;

	// one configuration data word
	typedef logic [lr_pkg::CFG_W-1:0] cfg_word_t;

	// one input word as the sender presents it
	typedef struct {
		logic                      kind;
		logic signed [COORD_W-1:0] fx, fy, tx, ty;
		logic [15:0]               color;
	} line_word_t;

	// one pixel word as the block gives it
	typedef struct {
		logic signed [COORD_W-1:0] x, y;
		logic [15:0]               color;
		logic                      on_surf;
		logic                      last;
	} pixel_t;

	// Tracks the pen the way the block should, and holds the pixels still owed.
	class pixel_scoreboard;
		int          pen_x, pen_y, end_x, end_y, span_x, span_y, err;
		bit          left, up, drawing;
		logic [15:0] color;
		int          surf_w, surf_h;
		pixel_t      due[$];
		int          mismatches, checked, lines, ends_seen, on_seen;

		function new();
			surf_w = DIM_MAX;
			surf_h = DIM_MAX;
		endfunction

		function void set_surface(logic idx, cfg_word_t val);
			int v;
			v = (int'(val) > DIM_MAX) ? DIM_MAX : int'(val);
			if (idx == lr_pkg::CFG_SURFACE_WIDTH)
				surf_w = v;
			else
				surf_h = v;
		endfunction

		// Note an accepted word; return 1 if the block had to act on it.
		function bit take_word(line_word_t w);
			pixel_t p;
			int     e2;
			if (w.kind == lr_pkg::KIND_LOAD) begin
				pen_x = int'(w.fx);
				pen_y = int'(w.fy);
				end_x = int'(w.tx);
				end_y = int'(w.ty);
				left = end_x < pen_x;
				up = end_y < pen_y;
				span_x = left ? pen_x - end_x : end_x - pen_x;
				span_y = up ? pen_y - end_y : end_y - pen_y;
				err = span_x - span_y;
				color = w.color;
				drawing = 1;
				lines++;
				return 1;
			end
			if (!drawing)
				return 0;
			p.x = pen_x[COORD_W-1:0];
			p.y = pen_y[COORD_W-1:0];
			p.color = color;
			p.on_surf = pen_x >= 0 && pen_x < surf_w && pen_y >= 0 && pen_y < surf_h;
			p.last = pen_x == end_x && pen_y == end_y;
			due.push_back(p);
			if (p.last) begin
				drawing = 0;
			end else begin
				e2 = 2 * err;
				if (e2 > -span_y) begin
					err -= span_y;
					pen_x += left ? -1 : 1;
				end
				if (e2 < span_x) begin
					err += span_x;
					pen_y += up ? -1 : 1;
				end
			end
			return 1;
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pixel x=%0d y=%0d color=%h on=%b last=%b",
						got.x, got.y, got.color, got.on_surf, got.last);
				return;
			end
			want = due.pop_front();
			checked++;
			if (want.last)
				ends_seen++;
			if (want.on_surf)
				on_seen++;
			if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
					got.on_surf !== want.on_surf || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("pixel mismatch: expected x=%0d y=%0d color=%h on=%b last=%b,",
						want.x, want.y, want.color, want.on_surf, want.last);
					$display("                got      x=%0d y=%0d color=%h on=%b last=%b",
						got.x, got.y, got.color, got.on_surf, got.last);
				end
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic                      kind = lr_pkg::KIND_STEP;
	logic signed [COORD_W-1:0] from_x = '0, from_y = '0, to_x = '0, to_y = '0;
	logic [15:0]               line_color = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [COORD_W-1:0] pixel_x, pixel_y;
	logic [15:0]               pixel_color;
	logic                      on_surface, last_pixel;
	logic                      cfg_write = 1'b0;
	logic                      cfg_index = lr_pkg::CFG_SURFACE_WIDTH;
	cfg_word_t                 cfg_data = '0;

	pixel_scoreboard sb = new();
	bit              calm;     // no idling on either side while set
	int              counted;  // words the block acted on
	int              cycles;

	line_rasterizer #(.COORD_WIDTH(COORD_W), .MAX_DIM(DIM_MAX)) u_top (.*);

	initial forever #4 clk = ~clk;

	// Stop a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Stall the pixel side in about one cycle of five, except in the calm stretch.
	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < 19);

	// Watch the pixel side. Sample at the falling edge, where everything is settled,
	// and hand the word over at the rising edge that takes it.
	initial begin
		pixel_t got;
		bit     take;
		forever begin
			@(negedge clk);
			take = arst_n && out_valid && !out_stall;
			got.x = pixel_x;
			got.y = pixel_y;
			got.color = pixel_color;
			got.on_surf = on_surface;
			got.last = last_pixel;
			@(posedge clk);
			if (take)
				sb.check_pixel(got);
		end
	end

	// Present one word and hold it until the block takes it. Called at a rising edge.
	task automatic send_word(line_word_t w);
		bit took;
		while (!calm && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= w.kind;
		from_x <= w.fx;
		from_y <= w.fy;
		to_x <= w.tx;
		to_y <= w.ty;
		line_color <= w.color;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
		if (sb.take_word(w))
			counted++;
	endtask

	// Step word with junk in the fields the block must ignore.
	function automatic line_word_t step_word();
		line_word_t w;
		w.kind = lr_pkg::KIND_STEP;
		w.fx = COORD_W'($urandom);
		w.fy = COORD_W'($urandom);
		w.tx = COORD_W'($urandom);
		w.ty = COORD_W'($urandom);
		w.color = 16'($urandom);
		return w;
	endfunction

	function automatic line_word_t load_word(int x0, int y0, int x1, int y1,
			logic [15:0] c);
		line_word_t w;
		w.kind = lr_pkg::KIND_LOAD;
		w.fx = x0[COORD_W-1:0];
		w.fy = y0[COORD_W-1:0];
		w.tx = x1[COORD_W-1:0];
		w.ty = y1[COORD_W-1:0];
		w.color = c;
		return w;
	endfunction

	// Load a line and ask for a number of pixels.
	task automatic draw(line_word_t ld, int steps);
		send_word(ld);
		repeat (steps) send_word(step_word());
	endtask

	// Drop valid and wait until every owed pixel is back, then let the pipe settle.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write both surface size registers back to back. Only while idle.
	task automatic set_surface_size(cfg_word_t w, cfg_word_t h);
		cfg_write <= 1'b1;
		cfg_index <= lr_pkg::CFG_SURFACE_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		sb.set_surface(lr_pkg::CFG_SURFACE_WIDTH, w);
		cfg_index <= lr_pkg::CFG_SURFACE_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		sb.set_surface(lr_pkg::CFG_SURFACE_HEIGHT, h);
		cfg_write <= 1'b0;
	endtask

	// Coordinate that lands near an edge of the surface most of the time.
	function automatic int pick_coord(int dim);
		case ($urandom_range(2))
			0: return $urandom_range(6) - 3;
			1: return dim + $urandom_range(6) - 3;
			default: return $urandom_range(dim + 16) - 8;
		endcase
	endfunction

	// One surface setting: mostly short lines walked to the end, some cut short or
	// overrun, some lines anywhere in the coordinate range, and a little noise.
	task automatic run_phase(cfg_word_t w, cfg_word_t h, int n_items, bit with_pause);
		int         start, x0, y0, x1, y1, dx, dy, len, steps, roll;
		bit         paused;
		line_word_t wd;
		set_surface_size(w, h);
		start = counted;
		paused = 0;
		while (counted - start < n_items) begin
			// hold off the sender once until every pixel owed has come back
			if (with_pause && !paused && counted - start > n_items / 2) begin
				in_valid <= 1'b0;
				paused = 1;
				do @(posedge clk); while (sb.due.size() != 0);
			end
			roll = $urandom_range(99);
			if (roll < 80) begin
				x0 = pick_coord(sb.surf_w);
				y0 = pick_coord(sb.surf_h);
				x1 = x0 + $urandom_range(24) - 12;
				y1 = y0 + $urandom_range(24) - 12;
				dx = x1 - x0;
				dy = y1 - y0;
				if (dx < 0)
					dx = -dx;
				if (dy < 0)
					dy = -dy;
				len = (dx > dy ? dx : dy) + 1;
				roll = $urandom_range(99);
				if (roll < 75)
					steps = len;
				else if (roll < 90)
					steps = $urandom_range(len);  // cut short by the next load
				else
					steps = len + $urandom_range(1, 2);  // overrun into idle steps
				draw(load_word(x0, y0, x1, y1, 16'($urandom)), steps);
			end else if (roll < 90) begin
				wd = step_word();
				wd.kind = lr_pkg::KIND_LOAD;
				draw(wd, $urandom_range(6));
			end else begin
				wd = step_word();
				wd.kind = $urandom_range(1) ? lr_pkg::KIND_STEP : lr_pkg::KIND_LOAD;
				send_word(wd);
			end
		end
		drain();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset surface size.
		send_word(step_word());                                  // step with no line
		draw(load_word(0, 0, 0, 0, 16'hFFFF), 2);                // single pixel, then idle
		draw(load_word(-32768, -32768, 32767, 32767, 16'h0000), 3);
		// this load drops the diagonal above in mid walk
		draw(load_word(32767, -32768, -32768, 32767, 16'hA5A5), 2);
		draw(load_word(5, 3, 0, 3, 16'h5A5A), 6);                // horizontal, leftward
		draw(load_word(2, 0, 2, -3, 16'h07E0), 4);               // vertical, upward
		draw(load_word(4094, 4095, 4097, 4093, 16'hF800), 4);    // across the far corner
		drain();

		// Random part over several surface sizes.
		run_phase(13'd0, cfg_word_t'(DIM_MAX), 105, 0);
		run_phase(cfg_word_t'(DIM_MAX), 13'd0, 105, 0);
		run_phase(13'd1, 13'd1, 105, 0);
		calm = 1;
		run_phase(13'h1FFF, 13'h1FFF, 105, 0);  // saturates to the full size
		calm = 0;
		run_phase(13'd16, 13'd16, 105, 1);
		run_phase(cfg_word_t'($urandom_range(8191)), cfg_word_t'($urandom_range(8191)), 105, 0);
		run_phase(cfg_word_t'(DIM_MAX), cfg_word_t'(DIM_MAX), 105, 1);

		$display("%0d lines, %0d pixels checked (%0d on the surface, %0d line ends),",
			sb.lines, sb.checked, sb.on_seen, sb.ends_seen);
		$display("%0d mismatches; surfaces of zero, one, 16, random, full and oversize drawn on",
			sb.mismatches);
		if (sb.mismatches == 0 && sb.due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
